// File: rtl/gcs_pkg.sv
// Shared types, constants and the microcode program for the grid chase search block.
// No dependencies; imported by gcs_seq and grid_chase_depth_limited_search_top.
package gcs_pkg;

  localparam int GCS_GRID_COLS = 32;
  localparam int GCS_GRID_ROWS = 32;
  localparam int GCS_MAX_DEPTH = 16;

  localparam logic [4:0] SEARCH_DEPTH_RST = 5'd10;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic [4:0]  chaser_x;
    logic [4:0]  chaser_y;
    logic [4:0]  target_x;
    logic [4:0]  target_y;
  } in_item_t;

  typedef struct packed {
    logic [4:0] next_x;
    logic [4:0] next_y;
    logic       found;
  } out_item_t;

  typedef enum logic [1:0] {
    DIR_EAST  = 2'd0,
    DIR_WEST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_NORTH = 2'd3
  } dir_t;

  // One walk-stack entry: the cell before a level and the direction that level left by.
  typedef struct packed {
    logic [4:0] x;
    logic [4:0] y;
    dir_t       d;
  } stk_entry_t;

  typedef enum logic [2:0] {
    STEP_WAIT   = 3'd0,
    STEP_INIT   = 3'd1,
    STEP_PROBE  = 3'd2,
    STEP_CHECK  = 3'd3,
    STEP_HIT    = 3'd4,
    STEP_POP_RD = 3'd5,
    STEP_POP_WB = 3'd6,
    STEP_MISS   = 3'd7
  } upc_t;

  typedef enum logic [2:0] {
    ACT_ACCEPT    = 3'd0,
    ACT_INIT      = 3'd1,
    ACT_PROBE     = 3'd2,
    ACT_CHECK     = 3'd3,
    ACT_EMIT_HIT  = 3'd4,
    ACT_POP_RD    = 3'd5,
    ACT_POP_WB    = 3'd6,
    ACT_EMIT_MISS = 3'd7
  } act_t;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_IDLE_STAY = 3'd2,
    COND_D_DONE    = 3'd3,
    COND_NOT_HIT   = 3'd4,
    COND_L_ZERO    = 3'd5
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  typedef struct packed {
    logic idle_stay;
    logic d_done;
    logic hit;
    logic l_zero;
  } seq_flags_t;

  // The search program. A taken condition jumps to target, otherwise the next step follows.
  function automatic ctrl_word_t ucode_rom(upc_t pc);
    ctrl_word_t w;
    unique case (pc)
      STEP_WAIT:   w = '{act: ACT_ACCEPT,    cond: COND_IDLE_STAY, target: STEP_WAIT};
      STEP_INIT:   w = '{act: ACT_INIT,      cond: COND_NEVER,     target: STEP_WAIT};
      STEP_PROBE:  w = '{act: ACT_PROBE,     cond: COND_D_DONE,    target: STEP_POP_RD};
      STEP_CHECK:  w = '{act: ACT_CHECK,     cond: COND_NOT_HIT,   target: STEP_PROBE};
      STEP_HIT:    w = '{act: ACT_EMIT_HIT,  cond: COND_ALWAYS,    target: STEP_WAIT};
      STEP_POP_RD: w = '{act: ACT_POP_RD,    cond: COND_L_ZERO,    target: STEP_MISS};
      STEP_POP_WB: w = '{act: ACT_POP_WB,    cond: COND_ALWAYS,    target: STEP_PROBE};
      STEP_MISS:   w = '{act: ACT_EMIT_MISS, cond: COND_ALWAYS,    target: STEP_WAIT};
      default:     w = '{act: ACT_ACCEPT,    cond: COND_ALWAYS,    target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/gcs_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on gcs_pkg for the control word, the flags and the program.
module gcs_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  gcs_pkg::seq_flags_t flags,
  output gcs_pkg::ctrl_word_t ctrl,
  output logic                busy
);
  import gcs_pkg::*;

  upc_t pc_r;
  upc_t pc_nxt;
  logic taken;

  assign ctrl = ucode_rom(pc_r);
  assign busy = (pc_r != STEP_WAIT);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:     taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_IDLE_STAY: taken = flags.idle_stay;
      COND_D_DONE:    taken = flags.d_done;
      COND_NOT_HIT:   taken = !flags.hit;
      COND_L_ZERO:    taken = flags.l_zero;
      default:        taken = 1'b1;
    endcase
    pc_nxt = taken ? ctrl.target : upc_t'(pc_r + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: rtl/grid_chase_depth_limited_search_top.sv
// Top level of the grid chase search block: wall map, walk stack and search datapath.
// Depends on gcs_pkg and instantiates the microcode sequencer gcs_seq.
//
// Usage. An item is taken at a rising edge where start is high and busy is low.
// A load item (cmd = load) writes one 32-bit wall row into the map and marks that
// row as loaded; it finishes in the accepting cycle, busy stays low and no result
// follows. A search item starts a depth-first walk from the chaser cell, trying
// east, west, south and north in that order, never stepping straight back, and
// cutting off any walk that can no longer reach the target within the depth.
// Its single result shows on out_item for exactly one cycle, marked by out_valid;
// the receiver cannot stall it, so it must take the result in that cycle.
//
// A search sets up in an accept step and an init step, then checks each neighbor in
// a probe step, which reads the wall row memory, and a check step, which decides. A
// level that has run out of directions is found in a probe step and returns to the
// level above through a stack read step and a write-back step; an emit step then
// issues the result. The walk stack and the wall memory each give one access per
// cycle, and that sets the pace. busy is high throughout the search.
//
// Reset clears the loaded flags (all rows read as walls), the sequencer and the
// result strobe, and sets search_depth to 10. cfg_we writes search_depth; the user
// must assert it only while idle, as the block itself does not enforce it.
module grid_chase_depth_limited_search_top #(
  parameter int MAX_DEPTH = gcs_pkg::GCS_MAX_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  gcs_pkg::in_item_t  in_item,
  output logic               out_valid,
  output gcs_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);
  import gcs_pkg::*;

  // Level counter and stack index both cover 0..MAX_DEPTH.
  localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
  localparam int STK_DEPTH = MAX_DEPTH + 1;

  ctrl_word_t ctrl;
  seq_flags_t flags;

  gcs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Configuration and map state.
  logic [4:0]  search_depth_r;
  logic [31:0] loaded_r;
  logic [31:0] wall_mem [32];
  logic [31:0] row_rd_r;

  // Search state.
  logic [4:0]       goal_x_r, goal_y_r;
  logic [4:0]       cur_x_r, cur_y_r;
  logic [4:0]       prev_x_r, prev_y_r;
  logic [4:0]       first_x_r, first_y_r;
  logic [4:0]       nb_x_r, nb_y_r;
  logic             nb_off_r;
  logic [2:0]       d_r;
  logic [LVL_W-1:0] lvl_r;
  logic [LVL_W-1:0] limit_r;
  stk_entry_t       stk_mem [STK_DEPTH];
  stk_entry_t       stk_rd_r;

  logic      out_valid_r;
  out_item_t out_item_r;

  logic accept;
  assign accept = start && !busy;

  // Neighbor of the current cell in the current direction. Off-grid cells land on 32 or
  // above in the six-bit sums (a step below zero wraps) and fail the bound compare.
  logic [5:0] nx6, ny6;
  logic       n_off;
  always_comb begin
    nx6 = {1'b0, cur_x_r};
    ny6 = {1'b0, cur_y_r};
    case (dir_t'(d_r[1:0]))
      DIR_EAST:  nx6 = {1'b0, cur_x_r} + 6'd1;
      DIR_WEST:  nx6 = {1'b0, cur_x_r} - 6'd1;
      DIR_SOUTH: ny6 = {1'b0, cur_y_r} + 6'd1;
      DIR_NORTH: ny6 = {1'b0, cur_y_r} - 6'd1;
      default:   nx6 = {1'b0, cur_x_r};
    endcase
    n_off = (nx6 >= 6'(GCS_GRID_COLS)) || (ny6 >= 6'(GCS_GRID_ROWS));
  end

  // Decision on the registered neighbor, with its wall row now read.
  logic             is_wall, reverse, blocked, at_goal, hit, deeper, descend;
  logic [4:0]       dx, dy;
  logic [5:0]       goal_gap;
  logic [LVL_W-1:0] lvl_p1, remain;
  always_comb begin
    is_wall  = nb_off_r || !loaded_r[nb_y_r] || row_rd_r[5'd31 - nb_x_r];
    reverse  = (lvl_r != '0) && (nb_x_r == prev_x_r) && (nb_y_r == prev_y_r);
    blocked  = is_wall || reverse;
    at_goal  = (nb_x_r == goal_x_r) && (nb_y_r == goal_y_r);
    hit      = !blocked && at_goal;
    dx       = (nb_x_r >= goal_x_r) ? (nb_x_r - goal_x_r) : (goal_x_r - nb_x_r);
    dy       = (nb_y_r >= goal_y_r) ? (nb_y_r - goal_y_r) : (goal_y_r - nb_y_r);
    goal_gap = {1'b0, dx} + {1'b0, dy};
    lvl_p1   = lvl_r + LVL_W'(1);
    deeper   = lvl_p1 < limit_r;
    remain   = limit_r - lvl_p1;
    descend  = !blocked && !at_goal && deeper && (goal_gap <= 6'(remain));
  end

  assign flags.idle_stay = !(start && (in_item.cmd == CMD_SEARCH));
  assign flags.d_done    = d_r[2];
  assign flags.hit       = hit;
  assign flags.l_zero    = (lvl_r == '0);

  // Wall row memory: written by load items; the probe step's read feeds the check.
  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_ACCEPT && accept && in_item.cmd == CMD_LOAD) begin
      wall_mem[in_item.row_index] <= in_item.row_bits;
    end
    row_rd_r <= wall_mem[ny6[4:0]];
  end

  // Walk stack memory: pushed on each descent, read back when a level is done.
  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_CHECK && descend) begin
      stk_mem[lvl_r] <= '{x: prev_x_r, y: prev_y_r, d: dir_t'(d_r[1:0])};
    end
    if (ctrl.act == ACT_POP_RD && lvl_r != '0) begin
      stk_rd_r <= stk_mem[lvl_r - LVL_W'(1)];
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_depth_r <= SEARCH_DEPTH_RST;
      loaded_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        search_depth_r <= cfg_wdata;
      end
      if (ctrl.act == ACT_ACCEPT && accept && in_item.cmd == CMD_LOAD) begin
        loaded_r[in_item.row_index] <= 1'b1;
      end
      out_valid_r <= (ctrl.act == ACT_EMIT_HIT) || (ctrl.act == ACT_EMIT_MISS);
    end
  end

  // Search datapath driven by the current control word.
  always_ff @(posedge clk) begin
    case (ctrl.act)
      ACT_ACCEPT: begin
        if (accept) begin
          cur_x_r  <= in_item.chaser_x;
          cur_y_r  <= in_item.chaser_y;
          goal_x_r <= in_item.target_x;
          goal_y_r <= in_item.target_y;
        end
      end
      ACT_INIT: begin
        lvl_r <= '0;
        d_r   <= 3'd0;
        // A depth of zero acts as one; a depth beyond the stack acts as its limit.
        if (search_depth_r == 5'd0) begin
          limit_r <= LVL_W'(1);
        end else if (search_depth_r > 5'(MAX_DEPTH)) begin
          limit_r <= LVL_W'(MAX_DEPTH);
        end else begin
          limit_r <= search_depth_r[LVL_W-1:0];
        end
      end
      ACT_PROBE: begin
        nb_x_r   <= nx6[4:0];
        nb_y_r   <= ny6[4:0];
        nb_off_r <= n_off;
      end
      ACT_CHECK: begin
        // At the top level every open neighbor is a candidate first step.
        if (!blocked && lvl_r == '0) begin
          first_x_r <= nb_x_r;
          first_y_r <= nb_y_r;
        end
        if (descend) begin
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
          cur_x_r  <= nb_x_r;
          cur_y_r  <= nb_y_r;
          d_r      <= 3'd0;
          lvl_r    <= lvl_p1;
        end else if (!hit) begin
          d_r <= d_r + 3'd1;
        end
      end
      ACT_EMIT_HIT: begin
        out_item_r <= '{next_x: first_x_r, next_y: first_y_r, found: 1'b1};
      end
      ACT_POP_RD: begin
      end
      ACT_POP_WB: begin
        cur_x_r  <= prev_x_r;
        cur_y_r  <= prev_y_r;
        prev_x_r <= stk_rd_r.x;
        prev_y_r <= stk_rd_r.y;
        d_r      <= {1'b0, stk_rd_r.d} + 3'd1;
        lvl_r    <= lvl_r - LVL_W'(1);
      end
      ACT_EMIT_MISS: begin
        // Back at the top level, the current cell is the chaser itself.
        out_item_r <= '{next_x: cur_x_r, next_y: cur_y_r, found: 1'b0};
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
